// ===== hw/rtl/pts_pkg.sv =====
// Shared widths and the control bundle for the pan/tilt slew tracker.
// No dependencies; used by pts_div and pan_tilt_slew_tracker.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
	localparam int POS_W   = 10;
	localparam int PULSE_W = 8;
	localparam int DEPTH   = 128;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int SUM_W   = 17;
	localparam int NUM_W   = POS_W + PULSE_W + 1;
	localparam int DEN_W   = POS_W;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_LOW      = 3'd1;
	localparam logic [2:0] REG_HIGH     = 3'd2;
	localparam logic [2:0] REG_CENTER   = 3'd3;
	localparam logic [2:0] REG_STEP     = 3'd4;
	localparam logic [2:0] REG_IN_MAX   = 3'd5;
	localparam logic [2:0] REG_FILT_EN  = 3'd6;
	localparam logic [2:0] REG_FILT_LEN = 3'd7;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pts_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pts_pkg::div_req_t        req,
	output logic                          done,
	output logic [pts_pkg::NUM_W-1:0]     quotient
);
	logic [pts_pkg::DEN_W-1:0] rem_q, div_q;
	logic [pts_pkg::NUM_W-1:0] quo_q;
	logic [pts_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q, done_q;
	logic [pts_pkg::DEN_W:0]   sh, diff;
	logic                      ge;

	assign sh   = {rem_q, quo_q[pts_pkg::NUM_W-1]};
	assign ge   = sh >= {1'b0, div_q};
	assign diff = sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pts_pkg::CNT_W'(pts_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pts_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pts_pkg::DEN_W-1:0] : sh[pts_pkg::DEN_W-1:0];
			quo_q <= {quo_q[pts_pkg::NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/pan_tilt_slew_tracker.sv =====
// Pan/tilt servo slew tracker: one result word per input word.
// With the filter on, each word passes through the two serial dividers (average,
// then map); with it off, only the map divide; when disabled or on the
// initializing tick, no divide. One word is worked at a time, so a new word is
// taken only after the last one moves into the output register, which waits on a stall.
// Reset (arst_n low) clears control state, held pulses, filter index/count/sum
// and loads the register defaults; the history memory is not cleared.
// Depends on pts_pkg and pts_div.
`timescale 1ns / 1ps
`default_nettype none
module pan_tilt_slew_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // pan_target[9:0], tilt_target[19:10], zero fill
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // pan_pulse[7:0], tilt_pulse[15:8], drive_on[16]
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	localparam int PW = pts_pkg::POS_W;
	localparam int UW = pts_pkg::PULSE_W;
	localparam int IW = pts_pkg::IDX_W;
	localparam int SW = pts_pkg::SUM_W;
	localparam int NW = pts_pkg::NUM_W;
	localparam int QW = NW + 2;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_PREP = 11'b00000000010,
		ST_RD   = 11'b00000000100,
		ST_UPD  = 11'b00000001000,
		ST_AVGS = 11'b00000010000,
		ST_AVGW = 11'b00000100000,
		ST_MUL  = 11'b00001000000,
		ST_DIVS = 11'b00010000000,
		ST_DIVW = 11'b00100000000,
		ST_SLEW = 11'b01000000000,
		ST_FIN  = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic          en_q, filt_en_q;
	logic [UW-1:0] low_q, high_q, center_q, step_q;
	logic [PW-1:0] in_max_q;
	logic [6:0]    filt_len_q;

	// tracking and filter state
	logic          ready_q;
	logic [UW-1:0] held_pan_q, held_tilt_q;
	logic [IW-1:0] idx_q, pos_q;
	logic [7:0]    hcnt_q, win_len_q;
	logic [SW-1:0] sum_pan_q, sum_tilt_q;
	logic [2*PW-1:0] hist_mem [pts_pkg::DEPTH];
	logic [2*PW-1:0] rd_q;

	// per-word working registers
	logic [PW-1:0] t_pan_q, t_tilt_q;
	logic [NW-1:0] prod_pan_q, prod_tilt_q;
	logic [UW-1:0] res_pan_q, res_tilt_q;
	logic          res_on_q;
	logic          out_valid_q;
	logic [23:0]   out_data_q;

	logic [PW-1:0] in_pan, in_tilt, sat_pan, sat_tilt;
	logic [7:0]    win;
	logic          accept;

	assign in_pan   = s_axis_tdata[PW-1:0];
	assign in_tilt  = s_axis_tdata[2*PW-1:PW];
	assign sat_pan  = (in_pan  > in_max_q) ? in_max_q : in_pan;
	assign sat_tilt = (in_tilt > in_max_q) ? in_max_q : in_tilt;
	assign win      = (filt_len_q == 7'd0) ? 8'd1 : {1'b0, filt_len_q};
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;

	// config writes; the user must write only while idle (not enforced here), so no interlock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b0;
			low_q      <= UW'(50);
			high_q     <= UW'(250);
			center_q   <= UW'(150);
			step_q     <= UW'(1);
			in_max_q   <= PW'(300);
			filt_en_q  <= 1'b0;
			filt_len_q <= 7'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				pts_pkg::REG_ENABLE:   en_q       <= cfg_data[0];
				pts_pkg::REG_LOW:      low_q      <= cfg_data[UW-1:0];
				pts_pkg::REG_HIGH:     high_q     <= cfg_data[UW-1:0];
				pts_pkg::REG_CENTER:   center_q   <= cfg_data[UW-1:0];
				pts_pkg::REG_STEP:     step_q     <= cfg_data[UW-1:0];
				pts_pkg::REG_IN_MAX:   in_max_q   <= cfg_data[PW-1:0];
				pts_pkg::REG_FILT_EN:  filt_en_q  <= cfg_data[0];
				pts_pkg::REG_FILT_LEN: filt_len_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// running window sums: add the new sample, drop the one it overwrites once full
	logic          full;
	logic [SW-1:0] nsum_pan, nsum_tilt;
	assign full      = (hcnt_q == win_len_q);
	assign nsum_pan  = sum_pan_q + SW'(t_pan_q)
		- (full ? SW'(rd_q[PW-1:0]) : SW'(0));
	assign nsum_tilt = sum_tilt_q + SW'(t_tilt_q)
		- (full ? SW'(rd_q[2*PW-1:PW]) : SW'(0));

	// map: |high-low| and its sign
	logic          down;
	logic [UW-1:0] span;
	assign down = high_q < low_q;
	assign span = down ? (low_q - high_q) : (high_q - low_q);

	// dividers, one per axis, run in lockstep
	pts_pkg::div_req_t req_pan, req_tilt;
	logic          done_pan, done_tilt;
	logic [NW-1:0] quo_pan, quo_tilt;
	logic          div_avg;

	assign div_avg = (state_q == ST_AVGS);
	always_comb begin
		req_pan.start     = div_avg || (state_q == ST_DIVS);
		req_tilt.start    = req_pan.start;
		req_pan.dividend  = div_avg ? NW'(sum_pan_q)  : prod_pan_q;
		req_tilt.dividend = div_avg ? NW'(sum_tilt_q) : prod_tilt_q;
		req_pan.divisor   = div_avg ? PW'(hcnt_q) : in_max_q;
		req_tilt.divisor  = req_pan.divisor;
	end

	pts_div u_div_pan (
		.clk(clk), .arst_n(arst_n), .req(req_pan), .done(done_pan), .quotient(quo_pan)
	);
	pts_div u_div_tilt (
		.clk(clk), .arst_n(arst_n), .req(req_tilt), .done(done_tilt), .quotient(quo_tilt)
	);

	// halve the quotient, rounding ties upward, then offset by low; an average
	// taken under a larger in_max may map far past the limits, so keep full width
	function automatic logic [UW-1:0] slew(
		input logic [NW-1:0] mag, input logic dn, input logic zero_max,
		input logic [UW-1:0] held, input logic [UW-1:0] lo, input logic [UW-1:0] hi,
		input logic [UW-1:0] stp
	);
		logic signed [QW-1:0] q, mapped, h;
		logic [NW-1:0]        half;
		begin
			if (dn)
				half = (mag == '0) ? '0 : ((mag - 1'b1) >> 1);
			else
				half = (mag + 1'b1) >> 1;
			q = $signed({2'b00, half});
			if (dn)
				q = -q;
			if (zero_max)
				q = '0;
			mapped = q + $signed(QW'(lo));
			h = $signed(QW'(held));
			if (mapped > h)
				h = h + $signed(QW'(stp));
			else
				h = h - $signed(QW'(stp));
			if (h > $signed(QW'(hi)))
				h = $signed(QW'(hi));
			if (h < $signed(QW'(lo)))
				h = $signed(QW'(lo));
			slew = h[UW-1:0];
		end
	endfunction

	// history memory: one 20-bit row holds both axes
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP)
			rd_q <= hist_mem[(idx_q >= win_len_q[IW-1:0]) ? IW'(0) : idx_q];
		if (state_q == ST_UPD)
			hist_mem[pos_q] <= {t_tilt_q, t_pan_q};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			held_pan_q  <= '0;
			held_tilt_q <= '0;
			idx_q       <= '0;
			hcnt_q      <= '0;
			win_len_q   <= '0;
			sum_pan_q   <= '0;
			sum_tilt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						t_pan_q  <= sat_pan;
						t_tilt_q <= sat_tilt;
						if (!en_q) begin
							// drive off, clear ready, hold everything else
							ready_q   <= 1'b0;
							res_pan_q <= '0;
							res_tilt_q <= '0;
							res_on_q  <= 1'b0;
							state_q   <= ST_FIN;
						end else if (!ready_q) begin
							// park: pan to center, tilt to low
							ready_q     <= 1'b1;
							held_pan_q  <= center_q;
							held_tilt_q <= low_q;
							res_pan_q   <= center_q;
							res_tilt_q  <= low_q;
							res_on_q    <= 1'b1;
							state_q     <= ST_FIN;
						end else if (filt_en_q) begin
							if (win != win_len_q) begin
								// restart the window on a length change
								win_len_q  <= win;
								idx_q      <= '0;
								hcnt_q     <= '0;
								sum_pan_q  <= '0;
								sum_tilt_q <= '0;
							end
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_PREP: begin
					pos_q   <= (idx_q >= win_len_q[IW-1:0]) ? IW'(0) : idx_q;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					sum_pan_q  <= nsum_pan;
					sum_tilt_q <= nsum_tilt;
					if (!full)
						hcnt_q <= hcnt_q + 1'b1;
					idx_q <= ((8'(pos_q) + 8'd1) >= win_len_q) ? IW'(0) : (pos_q + 1'b1);
					state_q <= ST_AVGS;
				end
				ST_AVGS: state_q <= ST_AVGW;
				ST_AVGW: begin
					if (done_pan) begin
						t_pan_q  <= quo_pan[PW-1:0];
						t_tilt_q <= quo_tilt[PW-1:0];
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_pan_q  <= {NW'(t_pan_q) * NW'(span)} << 1;
					prod_tilt_q <= {NW'(t_tilt_q) * NW'(span)} << 1;
					state_q     <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (done_tilt)
						state_q <= ST_SLEW;
				end
				ST_SLEW: begin
					res_pan_q <= slew(quo_pan, down, in_max_q == '0, held_pan_q,
						low_q, high_q, step_q);
					res_tilt_q <= slew(quo_tilt, down, in_max_q == '0, held_tilt_q,
						low_q, high_q, step_q);
					held_pan_q <= slew(quo_pan, down, in_max_q == '0, held_pan_q,
						low_q, high_q, step_q);
					held_tilt_q <= slew(quo_tilt, down, in_max_q == '0, held_tilt_q,
						low_q, high_q, step_q);
					res_on_q <= 1'b1;
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					// hand the word to the output register once it is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {7'd0, res_on_q, res_tilt_q, res_pan_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire
